FILE: rtl/core/berlekamp_massey_gf2m_unit_macros.svh
// assertion macros for the berlekamp-massey unit checker
// no dependencies
`ifndef BERLEKAMP_MASSEY_GF2M_UNIT_MACROS_SVH
`define BERLEKAMP_MASSEY_GF2M_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define BM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`endif

FILE: rtl/core/bmgf_pkg.sv
// shared constants and types for the berlekamp-massey unit
// no dependencies
package bmgf_pkg;
  localparam int unsigned SeqMaxDef    = 32;
  localparam int unsigned FieldBitsDef = 64;
  localparam int unsigned CfgDegree    = 0;
  localparam int unsigned CfgTail      = 1;

  typedef enum logic [1:0] {
    MUL_IDLE = 2'b01,
    MUL_RUN  = 2'b10
  } mul_state_e;
endpackage

FILE: rtl/core/bmgf_mul.sv
// bit-serial gf(2^m) multiplier, one bit of b per cycle
// depends on bmgf_pkg
module bmgf_mul import bmgf_pkg::*; #(
  parameter int unsigned FieldBits = FieldBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FieldBits-1:0] a_i,
  input  logic [FieldBits-1:0] b_i,
  input  logic [FieldBits-1:0] mask_i,
  input  logic [FieldBits-1:0] tail_i,
  input  logic [6:0]           m_i,
  output logic                 done_o,
  output logic [FieldBits-1:0] p_o
);
  mul_state_e             state_q, state_d;
  logic [FieldBits-1:0]   a_q, b_q, r_q, r_d, r_sh;
  logic [6:0]             cnt_q, cnt_d;
  logic                   top;

  // shift-and-reduce step, msb of b first
  always_comb begin
    top  = |(r_q & (mask_i & ~(mask_i >> 1)));
    r_sh = (r_q << 1) & mask_i;
    if (top) r_sh = r_sh ^ tail_i;
    r_d = r_sh;
    if (b_q[cnt_q[5:0]]) r_d = r_d ^ a_q;
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      MUL_IDLE: if (start_i) begin
        state_d = MUL_RUN;
        cnt_d   = m_i - 7'd1;
      end
      MUL_RUN: begin
        if (cnt_q == 7'd0) state_d = MUL_IDLE;
        else cnt_d = cnt_q - 7'd1;
      end
      default: state_d = MUL_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MUL_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == MUL_IDLE && start_i) begin
      a_q <= a_i & mask_i;
      b_q <= b_i & mask_i;
      r_q <= '0;
    end else if (state_q == MUL_RUN) begin
      r_q <= r_d;
    end
  end

  assign done_o = (state_q == MUL_RUN) && (cnt_q == 7'd0);
  assign p_o    = r_d;
endmodule

FILE: rtl/core/berlekamp_massey_gf2m_unit.sv
// berlekamp-massey over gf(2^m), top level with sequencer and polynomial store
// depends on bmgf_pkg and bmgf_mul
//
// usage: sequence elements arrive on seq_value_i/last_i with valid/ready.
// configuration (field_degree index 0, poly_tail index 1) is written on the
// cfg channel while idle. each field product is one serial multiply on the
// single shared multiplier: discrepancy needs up to L products; for an item
// with nonzero discrepancy the inverse takes 2(m-1) products, the scale
// factor one product and the correction up to SEQ_MAX products.
// a last item then emits L+1 result items, one per
// cycle while the receiver takes them; a stall simply holds the current item.
// in_ready_o is low while an item is worked on or results are pending.
// reset loads field degree 64, tail 27 and the empty connection polynomial,
// all in flip-flops, so no clearing pass is needed.
// the polynomial store is the only buffer: the next item is taken once the
// last result item of a run has been accepted.
module berlekamp_massey_gf2m_unit import bmgf_pkg::*; #(
  parameter int unsigned SeqMax    = SeqMaxDef,
  parameter int unsigned FieldBits = FieldBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_index_i,
  input  logic [63:0]          cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [FieldBits-1:0] seq_value_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [FieldBits-1:0] coefficient_o,
  output logic [5:0]           coef_index_o,
  output logic [5:0]           degree_o,
  output logic                 overflow_o,
  output logic                 final_res_o
);
  localparam int unsigned IW = $clog2(SeqMax + 1);
  localparam int unsigned HW = $clog2(SeqMax);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DISC  = 8'b00000010,
    S_INVSQ = 8'b00000100,
    S_INVML = 8'b00001000,
    S_COEF  = 8'b00010000,
    S_UPD   = 8'b00100000,
    S_EMIT  = 8'b01000000,
    S_WAIT  = 8'b10000000
  } state_e;

  // coefficient zero of every polynomial is always one, so only 1..SeqMax are held
  state_e               state_q;
  logic [6:0]           deg_q;
  logic [63:0]          tail_q;
  logic [FieldBits-1:0] conn_q [1:SeqMax];
  logic [FieldBits-1:0] prev_q [1:SeqMax];
  logic [FieldBits-1:0] save_q [1:SeqMax];
  logic [FieldBits-1:0] hist_q [SeqMax];
  logic [5:0]           len_q, gap_q, cnt_q;
  logic [FieldBits-1:0] ldisc_q, d_q, x_q, r_q, coef_q;
  logic [6:0]           k_q;
  logic [5:0]           j_q;
  logic                 ovf_q, last_q, mstart_q, grow_q;
  logic [6:0]           m;
  logic [FieldBits-1:0] mask, tail, ma, mb, mp;
  logic                 mdone;
  logic [IW:0]          tgt;

  // effective degree and mask
  always_comb begin
    m = deg_q;
    if (m < 7'd2) m = 7'd2;
    if (m > 7'(FieldBits)) m = 7'(FieldBits);
    mask = '0;
    for (int b = 0; b < FieldBits; b++) mask[b] = (7'(b) < m);
    tail = tail_q[FieldBits-1:0] & mask;
  end

  // operand selection for the shared multiplier
  always_comb begin
    ma = coef_q;
    mb = (j_q == 6'd0) ? FieldBits'(1) : prev_q[j_q[IW-1:0]];
    unique case (state_q)
      S_DISC:  begin
        ma = conn_q[j_q[IW-1:0]];
        mb = hist_q[HW'(cnt_q - j_q)];
      end
      S_INVSQ: begin ma = x_q; mb = x_q; end
      S_INVML: begin ma = r_q; mb = x_q; end
      S_COEF:  begin ma = d_q; mb = r_q; end
      default: ;
    endcase
  end

  bmgf_mul #(.FieldBits(FieldBits)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart_q), .a_i(ma), .b_i(mb), .mask_i(mask),
    .tail_i(tail), .m_i(m), .done_o(mdone), .p_o(mp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign coefficient_o = (k_q == 7'd0) ? FieldBits'(1) : (conn_q[k_q[IW-1:0]] & mask);
  assign coef_index_o  = k_q[5:0];
  assign degree_o      = len_q;
  assign overflow_o    = ovf_q;
  assign final_res_o   = (k_q[5:0] == len_q);
  assign tgt           = (IW+1)'(j_q) + (IW+1)'(gap_q);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      deg_q    <= 7'd64;
      tail_q   <= 64'd27;
      len_q    <= '0;
      gap_q    <= 6'd1;
      cnt_q    <= '0;
      ldisc_q  <= FieldBits'(1);
      ovf_q    <= 1'b0;
      mstart_q <= 1'b0;
      last_q   <= 1'b0;
      grow_q   <= 1'b0;
      j_q      <= '0;
      k_q      <= '0;
      for (int i = 1; i <= SeqMax; i++) begin
        conn_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      mstart_q <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == 1'(CfgDegree)) deg_q <= cfg_data_i[6:0];
        else tail_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: if (in_valid_i) begin
          last_q <= last_i;
          k_q    <= '0;
          if (32'(cnt_q) < SeqMax) begin
            hist_q[cnt_q[HW-1:0]] <= seq_value_i & mask;
            d_q <= seq_value_i & mask;
            j_q <= 6'd1;
            state_q <= S_DISC;
            if (len_q != 0 && cnt_q != 0) mstart_q <= 1'b1;
          end else begin
            ovf_q   <= 1'b1;
            state_q <= last_i ? S_EMIT : S_IDLE;
          end
        end
        S_DISC: begin
          if (len_q == 0 || cnt_q == 0 || mdone) begin
            if (mdone) d_q <= d_q ^ mp;
            if (mdone && j_q < len_q && j_q < cnt_q) begin
              j_q <= j_q + 6'd1;
              mstart_q <= 1'b1;
            end else if ((mdone ? (d_q ^ mp) : d_q) == '0) begin
              gap_q <= gap_q + 6'd1;
              cnt_q <= cnt_q + 6'd1;
              state_q <= last_q ? S_EMIT : S_IDLE;
            end else begin
              grow_q <= ({len_q, 1'b0} <= {1'b0, cnt_q});
              for (int i = 1; i <= SeqMax; i++) save_q[i] <= conn_q[i];
              x_q <= ldisc_q & mask;
              r_q <= FieldBits'(1);
              j_q <= 6'd1;
              if (m > 7'd1 + 7'd0 && m != 7'd1) begin
                state_q <= S_INVSQ;
                mstart_q <= 1'b1;
              end
            end
          end
        end
        S_INVSQ: if (mdone) begin
          x_q <= mp;
          mstart_q <= 1'b1;
          state_q <= S_INVML;
        end
        S_INVML: if (mdone) begin
          if (7'(j_q) + 7'd1 < m) begin
            r_q <= mp;
            j_q <= j_q + 6'd1;
            state_q <= S_INVSQ;
          end else begin
            r_q <= ((ldisc_q & mask) != '0) ? mp : '0;
            state_q <= S_COEF;
          end
          mstart_q <= 1'b1;
        end
        S_COEF: if (mdone) begin
          coef_q <= mp;
          j_q <= '0;
          if (32'(gap_q) <= SeqMax) begin
            mstart_q <= 1'b1;
            state_q <= S_UPD;
          end else state_q <= S_WAIT;
        end
        S_UPD: if (mdone) begin
          conn_q[tgt[IW-1:0]] <= conn_q[tgt[IW-1:0]] ^ mp;
          if (32'(tgt) < SeqMax) begin
            j_q <= j_q + 6'd1;
            mstart_q <= 1'b1;
          end else state_q <= S_WAIT;
        end
        S_WAIT: begin
          if (grow_q) begin
            len_q <= cnt_q + 6'd1 - len_q;
            for (int i = 1; i <= SeqMax; i++) prev_q[i] <= save_q[i];
            ldisc_q <= d_q;
            gap_q <= 6'd1;
          end else gap_q <= gap_q + 6'd1;
          cnt_q <= cnt_q + 6'd1;
          state_q <= last_q ? S_EMIT : S_IDLE;
        end
        S_EMIT: if (out_ready_i) begin
          if (k_q[5:0] == len_q || 32'(k_q) == SeqMax) begin
            state_q <= S_IDLE;
            len_q <= '0;
            gap_q <= 6'd1;
            cnt_q <= '0;
            ldisc_q <= FieldBits'(1);
            ovf_q <= 1'b0;
            for (int i = 1; i <= SeqMax; i++) begin
              conn_q[i] <= '0;
              prev_q[i] <= '0;
            end
          end else k_q <= k_q + 7'd1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/bmgf_checker.sv
// port-level checker for the berlekamp-massey unit, bound to the top level
// depends on bmgf_pkg and the macros header
`include "berlekamp_massey_gf2m_unit_macros.svh"
module bmgf_checker import bmgf_pkg::*; #(
  parameter int unsigned FieldBits = FieldBitsDef
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [FieldBits-1:0] coefficient_o,
  input logic [5:0]           coef_index_o,
  input logic [5:0]           degree_o,
  input logic                 final_res_o
);
  // no input taken while results are shown
  `BM_ASSERT(a_excl, clk_i, rst_ni, out_valid_o |-> !in_ready_o)
  // final flag marks index equal to degree
  `BM_ASSERT(a_final, clk_i, rst_ni, (out_valid_o && final_res_o) |-> coef_index_o == degree_o)
  // stalled result holds
  `BM_ASSERT(a_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(coefficient_o))
  // run opens with index zero
  `BM_ASSERT(a_first, clk_i, rst_ni, $rose(out_valid_o) |-> coef_index_o == 6'd0)
endmodule

bind berlekamp_massey_gf2m_unit bmgf_checker #(.FieldBits(FieldBits)) u_bmgf_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .coefficient_o, .coef_index_o, .degree_o, .final_res_o
);

FILE: bench/bm_gf2m_checker.sv
// checker for the berlekamp-massey unit: watches all channels, predicts, compares
// depends on bmgf_pkg
module bm_gf2m_checker import bmgf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [63:0] seq_value_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] coefficient_i,
  input  logic [5:0]  coef_index_i,
  input  logic [5:0]  degree_i,
  input  logic        overflow_i,
  input  logic        final_res_i,
  output int          errors_o,
  output int          pending_o
);
  typedef struct packed {
    logic [63:0] coef;
    logic [5:0]  idx;
    logic [5:0]  deg;
    logic        ovf;
    logic        fin;
  } coef_t;

  coef_t       coef_q[$];
  logic [6:0]  fdeg;
  logic [63:0] ftail;
  logic [63:0] conn[0:32];
  logic [63:0] prev[0:32];
  logic [63:0] hist[0:31];
  int          lin_len, gap, seq_cnt;
  logic [63:0] last_d;
  bit          ovf_flag;
  int          errors;

  assign errors_o  = errors;
  assign pending_o = coef_q.size();

  function automatic int field_m();
    if (fdeg < 2) return 2;
    if (fdeg > 64) return 64;
    return fdeg;
  endfunction

  function automatic logic [63:0] field_mask();
    int m;
    m = field_m();
    return (m == 64) ? '1 : ((64'd1 << m) - 1);
  endfunction

  // shift-and-add product, msb of b first, reduced by the tail
  function automatic logic [63:0] gf_mul(logic [63:0] a, logic [63:0] b);
    logic [63:0] msk, tl, r;
    int          m;
    bit          top;
    m   = field_m();
    msk = field_mask();
    tl  = ftail & msk;
    a   = a & msk;
    b   = b & msk;
    r   = '0;
    for (int i = m; i > 0; i--) begin
      top = r[m-1];
      r   = (r << 1) & msk;
      if (top) r ^= tl;
      if (b[i-1]) r ^= a;
    end
    return r;
  endfunction

  // a^(2^m-2), zero maps to zero
  function automatic logic [63:0] gf_inv(logic [63:0] a);
    logic [63:0] x, r;
    x = a & field_mask();
    r = 64'd1;
    for (int k = 1; k < field_m(); k++) begin
      x = gf_mul(x, x);
      r = gf_mul(r, x);
    end
    return ((a & field_mask()) != 0) ? r : '0;
  endfunction

  function automatic void clear_run();
    for (int k = 0; k <= 32; k++) begin
      conn[k] = '0;
      prev[k] = '0;
    end
    conn[0]  = 64'd1;
    prev[0]  = 64'd1;
    lin_len  = 0;
    gap      = 1;
    last_d   = 64'd1;
    seq_cnt  = 0;
    ovf_flag = 0;
  endfunction

  // one synthesis step on a new element
  function automatic void absorb(logic [63:0] v);
    logic [63:0] d, scale;
    logic [63:0] saved[0:32];
    int          i;
    bit          grow;
    i       = seq_cnt;
    hist[i] = v;
    d       = v;
    for (int j = 1; j <= lin_len && j <= i; j++) d ^= gf_mul(conn[j], hist[i-j]);
    if (d == 0) begin
      gap++;
    end else begin
      grow  = (2 * lin_len <= i);
      saved = conn;
      scale = gf_mul(d, gf_inv(last_d));
      for (int j = 0; j + gap <= 32; j++) conn[j+gap] ^= gf_mul(scale, prev[j]);
      if (grow) begin
        lin_len = i + 1 - lin_len;
        prev    = saved;
        last_d  = d;
        gap     = 1;
      end else begin
        gap++;
      end
    end
    seq_cnt = i + 1;
  endfunction

  function automatic void take_item(logic [63:0] v, logic lst);
    coef_t e;
    if (seq_cnt < 32) absorb(v & field_mask());
    else ovf_flag = 1;
    if (lst) begin
      for (int k = 0; k <= lin_len; k++) begin
        e.coef = conn[k] & field_mask();
        e.idx  = 6'(k);
        e.deg  = 6'(lin_len);
        e.ovf  = ovf_flag;
        e.fin  = (k == lin_len);
        coef_q.push_back(e);
      end
      clear_run();
    end
  endfunction

  initial begin
    fdeg   = 7'd64;
    ftail  = 64'd27;
    errors = 0;
    clear_run();
  end

  // watch the channels at every edge
  always @(posedge clk_i) begin
    coef_t e, got;
    if (rst_ni) begin
      got = '{coefficient_i, coef_index_i, degree_i, overflow_i, final_res_i};
      if (out_valid_i && out_ready_i) begin
        if (coef_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %h", got);
        end else begin
          e = coef_q.pop_front();
          if (e != got) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp coef %h idx %0d deg %0d ovf %b fin %b, got coef %h idx %0d deg %0d ovf %b fin %b",
                       e.coef, e.idx, e.deg, e.ovf, e.fin,
                       got.coef, got.idx, got.deg, got.ovf, got.fin);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == 1'(CfgDegree)) fdeg = cfg_data_i[6:0];
        else ftail = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) take_item(seq_value_i, last_i);
    end
  end
endmodule

FILE: bench/berlekamp_massey_gf2m_unit_tb.sv
// testbench top for the berlekamp-massey unit: clock, reset, stimulus, verdict
// depends on bmgf_pkg, berlekamp_massey_gf2m_unit and bm_gf2m_checker
module berlekamp_massey_gf2m_unit_tb;
  import bmgf_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid = 0, cfg_index = 0;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 0, last = 0;
  logic [63:0] seq_value = '0;
  logic        out_ready = 0;
  logic        cfg_ready, in_ready, out_valid, overflow, final_res;
  logic [63:0] coefficient;
  logic [5:0]  coef_index, degree;
  int          errors, pending, idle_cycles, stall_left;

  // clock
  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  berlekamp_massey_gf2m_unit uut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .seq_value_i(seq_value), .last_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .coefficient_o(coefficient), .coef_index_o(coef_index),
    .degree_o(degree), .overflow_o(overflow), .final_res_o(final_res)
  );

  bm_gf2m_checker chk (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .seq_value_i(seq_value), .last_i(last),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .coefficient_i(coefficient), .coef_index_i(coef_index),
    .degree_i(degree), .overflow_i(overflow), .final_res_i(final_res),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, sometimes long, with stretches of none
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 0;
    end else if ($urandom_range(0, 9) < 3) begin
      stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60) :
                                                   $urandom_range(0, 2);
      out_ready  <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 60000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_item(logic [63:0] v, logic lst);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid  <= 1;
    seq_value <= v;
    last      <= lst;
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(logic idx, logic [63:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // let all result items drain, then change the field
  task automatic set_field(logic [63:0] dg, logic [63:0] tl);
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    write_reg(1'(CfgDegree), dg);
    write_reg(1'(CfgTail), tl);
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return '1;
      3:       return 64'd1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one run of random length ending in a last item
  task automatic send_run(int len);
    for (int k = 1; k <= len; k++) send_item(pick_value(), k == len);
  endtask

  int phase_deg[10]  = '{2, 8, 0, 127, 16, 5, 63, 33, 12, 64};
  int phase_cnt[10]  = '{20, 22, 10, 6, 22, 20, 6, 10, 20, 6};
  logic [63:0] tl;
  int sent, len;

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset field, extremes and short runs
    send_item('0, 1'b1);
    send_item('1, 1'b1);
    send_item(64'd1, 1'b0); send_item('0, 1'b0); send_item('0, 1'b1);
    send_item('1, 1'b0); send_item('1, 1'b0); send_item(64'h8000_0000_0000_0001, 1'b1);
    set_field(64'd3, 64'd3);
    send_item(64'd2, 1'b0); send_item(64'd3, 1'b0); send_item(64'd1, 1'b0);
    send_item('1, 1'b1);
    // overflow in the gf(2^3) field
    for (int k = 0; k < 34; k++) send_item(64'(k[1:0]), k == 33);

    // random phases over several fields
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 3))
        0:       tl = '0;
        1:       tl = '1;
        default: tl = {$urandom, $urandom};
      endcase
      set_field(64'(phase_deg[p]) | ({$urandom} << 7), tl);
      sent = 0;
      while (sent < phase_cnt[p]) begin
        if (phase_deg[p] >= 33) len = $urandom_range(1, 4);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(33, 36);
        else len = $urandom_range(1, 12);
        send_run(len);
        sent += len;
      end
    end
    set_field(64'd64, 64'd27);
    send_run(6);
    in_valid <= 0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end
endmodule
